[design/merge_sort_engine_assert.svh]
// assertion macros for the merge sort engine
`ifndef MERGE_SORT_ENGINE_ASSERT_SVH
`define MERGE_SORT_ENGINE_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication check
`define MSE_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("merge sort engine check failed");
// next-cycle implication check
`define MSE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("merge sort engine check failed");
`else
`define MSE_ASSERT_IMPL(label, clk, rst, ante, cons)
`define MSE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[design/msort_pkg.sv]
// shared types and constants for the merge sort engine
`default_nettype none

package msort_pkg;

  localparam int DATA_W = 32;

  // one input item
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } item_t;

  // one result item
  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last_res;
  } res_t;

endpackage

`default_nettype wire

[design/msort_ram.sv]
// element memory: one write port, two registered read ports
`default_nettype none

module msort_ram #(
  parameter int DEPTH = 8
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [$clog2(DEPTH)-1:0]        waddr,
  input  logic [msort_pkg::DATA_W-1:0]    wdata,
  input  logic                            re,
  input  logic [$clog2(DEPTH)-1:0]        raddr_a,
  input  logic [$clog2(DEPTH)-1:0]        raddr_b,
  output logic [msort_pkg::DATA_W-1:0]    rdata_a,
  output logic [msort_pkg::DATA_W-1:0]    rdata_b
);
  import msort_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read ports, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

[design/merge_sort_engine.sv]
// Stable ascending sort of up to MAX_ITEMS signed 32-bit values. Values are loaded one per
// cycle into memory 0 while item_stall is low; an item with last set closes the set (values
// beyond MAX_ITEMS are dropped, but a dropped last item still closes it). The set of N
// values is then sorted by ceil(log2 N) bottom-up merge passes that ping-pong between two
// memories; each merged element is read (both run heads from the source memory), then
// compared and written to the destination. Results then follow, each through a memory read
// and then the output register, the last one flagged, and are held while the receiver
// stalls. No new item is taken from the close of a set until its final result is in the
// output register. No clearing pass is needed after reset.
`default_nettype none
`include "merge_sort_engine_assert.svh"

module merge_sort_engine #(
  parameter int MAX_ITEMS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  msort_pkg::item_t  item,
  output logic              res_valid,
  input  logic              res_stall,
  output msort_pkg::res_t   res
);
  import msort_pkg::*;

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int XW = CW + 2;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_ITEMS);

  typedef enum logic [4:0] {
    S_LOAD = 5'b00001,
    S_RD   = 5'b00010,
    S_CMP  = 5'b00100,
    S_ERD  = 5'b01000,
    S_EOUT = 5'b10000
  } state_t;

  function automatic logic [XW-1:0] umin(input logic [XW-1:0] a, input logic [XW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  state_t             st;
  logic [CW-1:0]      count;
  logic [XW-1:0]      n;
  logic               src_sel;
  logic [XW-1:0]      width;
  logic [XW-1:0]      i;
  logic [XW-1:0]      j;
  logic [XW-1:0]      k;
  logic [XW-1:0]      mid;
  logic [XW-1:0]      hi;

  logic               item_acc;
  logic               full;
  logic [XW-1:0]      n_load;
  logic               out_free;

  logic               we0, we1, re0, re1;
  logic [AW-1:0]      waddr0;
  logic [DATA_W-1:0]  wdata0;
  logic [AW-1:0]      raddr_a, raddr_b;
  logic [DATA_W-1:0]  r0a, r0b, r1a, r1b;
  logic signed [DATA_W-1:0] da, db, merge_out;
  logic               take_left;
  logic [XW-1:0]      k_inc;
  logic [XW-1:0]      w2;
  logic               seg_end;
  logic               pass_end;

  // input side
  assign item_stall = (st != S_LOAD);
  assign item_acc   = item_valid && !item_stall;
  assign full       = (count == MAX_C);
  assign n_load     = XW'(count) + (full ? XW'(0) : XW'(1));
  assign out_free   = !res_valid || !res_stall;

  // memory port steering
  assign we0     = (st == S_LOAD && item_acc && !full) || (st == S_CMP && src_sel);
  assign waddr0  = (st == S_LOAD) ? count[AW-1:0] : k[AW-1:0];
  assign wdata0  = (st == S_LOAD) ? item.value : merge_out;
  assign we1     = (st == S_CMP) && !src_sel;
  assign re0     = (st == S_RD || st == S_ERD) && !src_sel;
  assign re1     = (st == S_RD || st == S_ERD) && src_sel;
  assign raddr_a = (st == S_ERD) ? k[AW-1:0] : i[AW-1:0];
  assign raddr_b = j[AW-1:0];

  msort_ram #(.DEPTH(MAX_ITEMS)) u_ram0 (
    .clk(clk), .we(we0), .waddr(waddr0), .wdata(wdata0),
    .re(re0), .raddr_a(raddr_a), .raddr_b(raddr_b),
    .rdata_a(r0a), .rdata_b(r0b)
  );

  msort_ram #(.DEPTH(MAX_ITEMS)) u_ram1 (
    .clk(clk), .we(we1), .waddr(k[AW-1:0]), .wdata(merge_out),
    .re(re1), .raddr_a(raddr_a), .raddr_b(raddr_b),
    .rdata_a(r1a), .rdata_b(r1b)
  );

  // merge step: left run wins ties
  always_comb begin
    da        = src_sel ? r1a : r0a;
    db        = src_sel ? r1b : r0b;
    take_left = (i < mid) && ((j >= hi) || (da <= db));
    merge_out = take_left ? da : db;
    k_inc     = k + XW'(1);
    w2        = width << 1;
    seg_end   = (k_inc == hi);
    pass_end  = seg_end && (hi == n);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_LOAD;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      // output register: loaded with a new result, cleared once transferred
      if (st == S_EOUT && out_free) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      unique case (st)
        S_LOAD: begin
          if (item_acc) begin
            if (item.last) begin
              count   <= '0;
              n       <= n_load;
              src_sel <= 1'b0;
              width   <= XW'(1);
              k       <= '0;
              i       <= '0;
              mid     <= XW'(1);
              j       <= XW'(1);
              hi      <= umin(XW'(2), n_load);
              st      <= (n_load == XW'(1)) ? S_ERD : S_RD;
            end else if (!full) begin
              count <= count + CW'(1);
            end
          end
        end
        S_RD: begin
          st <= S_CMP;
        end
        S_CMP: begin
          if (pass_end) begin
            src_sel <= !src_sel;
            width   <= w2;
            k       <= '0;
            if (w2 >= n) begin
              st <= S_ERD;
            end else begin
              st  <= S_RD;
              i   <= '0;
              mid <= umin(w2, n);
              j   <= umin(w2, n);
              hi  <= umin(w2 << 1, n);
            end
          end else if (seg_end) begin
            k   <= k_inc;
            st  <= S_RD;
            i   <= hi;
            mid <= umin(hi + width, n);
            j   <= umin(hi + width, n);
            hi  <= umin(hi + w2, n);
          end else begin
            k  <= k_inc;
            st <= S_RD;
            if (take_left) begin
              i <= i + XW'(1);
            end else begin
              j <= j + XW'(1);
            end
          end
        end
        S_ERD: begin
          st <= S_EOUT;
        end
        S_EOUT: begin
          if (out_free) begin
            res.sorted_value <= da;
            res.last_res     <= (k_inc == n);
            if (k_inc == n) begin
              st <= S_LOAD;
            end else begin
              k  <= k_inc;
              st <= S_ERD;
            end
          end
        end
        default: begin
          st <= S_LOAD;
        end
      endcase
    end
  end

  // checks
  `MSE_ASSERT_IMPL(a_count_range, clk, rst, 1'b1, count <= MAX_C)
  `MSE_ASSERT_IMPL(a_k_in_seg, clk, rst, st == S_CMP, (k < hi) && (hi <= n))
  `MSE_ASSERT_IMPL(a_heads_in_runs, clk, rst, st == S_CMP, (i <= mid) && (j <= hi) && (mid <= hi))
  `MSE_ASSERT_NEXT(a_last_ends_set, clk, rst, st == S_EOUT && out_free && k_inc == n, st == S_LOAD && count == '0 && res_valid && res.last_res)

endmodule

`default_nettype wire
